// File: hw/rtl/dhp_pkg.sv
// Shared types, constants and helper functions of the DTS header parser.
`default_nettype none

package dhp_pkg;

    // Header geometry
    localparam int PARSE_BYTES          = 14;
    localparam int HEADER_BYTES_DEFAULT = 14;
    localparam int PAYLOAD_BITS         = PARSE_BYTES * 8;
    localparam int HDR_WORDS            = PARSE_BYTES / 2;

    // Depth of the queue between collector and parser
    localparam int QUEUE_DEPTH = 2;

    // Sync pattern bytes
    localparam logic [7:0] SYNC_7F = 8'h7f;
    localparam logic [7:0] SYNC_FE = 8'hfe;
    localparam logic [7:0] SYNC_80 = 8'h80;
    localparam logic [7:0] SYNC_01 = 8'h01;
    localparam logic [7:0] SYNC_1F = 8'h1f;
    localparam logic [7:0] SYNC_FF = 8'hff;
    localparam logic [7:0] SYNC_E8 = 8'he8;
    localparam logic [7:0] SYNC_00 = 8'h00;
    localparam logic [7:0] SYNC_07 = 8'h07;
    localparam logic [7:0] SYNC_HI_NIBBLE = 8'hf0;

    // S/PDIF burst type codes
    localparam logic [3:0] BURST_NONE = 4'd0;
    localparam logic [3:0] BURST_512  = 4'd11;
    localparam logic [3:0] BURST_1024 = 4'd12;
    localparam logic [3:0] BURST_2048 = 4'd13;

    typedef enum logic [1:0] {
        FMT_BE16 = 2'd0,
        FMT_LE16 = 2'd1,
        FMT_BE14 = 2'd2,
        FMT_LE14 = 2'd3
    } stream_fmt_t;

    typedef logic [PARSE_BYTES-1:0][7:0] hdr_bytes_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
    } in_item_t;

    typedef struct packed {
        logic        sync_ok;
        logic        header_valid;
        logic [1:0]  stream_format;
        logic        crc_present;
        logic [7:0]  sample_blocks;
        logic [12:0] sample_count;
        logic [14:0] frame_bytes;
        logic [5:0]  channel_arrangement;
        logic [17:0] sample_rate_hz;
        logic [1:0]  lfe_mode;
        logic [3:0]  spdif_burst_type;
    } out_item_t;

    // Collected header handed from collector to queue
    typedef struct packed {
        logic       valid;
        hdr_bytes_t bytes;
    } hdr_push_t;

    // Queue fill status
    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    // Core sampling rate for a rate code, zero for reserved codes
    function automatic logic [17:0] rate_lookup(input logic [3:0] code);
        logic [17:0] rate;
        unique case (code)
            4'd1:    rate = 18'd8000;
            4'd2:    rate = 18'd16000;
            4'd3:    rate = 18'd32000;
            4'd6:    rate = 18'd11025;
            4'd7:    rate = 18'd22050;
            4'd8:    rate = 18'd44100;
            4'd11:   rate = 18'd12000;
            4'd12:   rate = 18'd24000;
            4'd13:   rate = 18'd48000;
            4'd14:   rate = 18'd96000;
            4'd15:   rate = 18'd192000;
            default: rate = 18'd0;
        endcase
        return rate;
    endfunction

    // Pack the payload bits of the seven header words, first bit at the MSB
    function automatic logic [PAYLOAD_BITS-1:0] unpack_payload(input hdr_bytes_t h,
                                                               input stream_fmt_t fmt);
        logic [PAYLOAD_BITS-1:0] pay;
        logic [15:0]             word;
        logic                    little;
        logic                    narrow;
        pay    = '0;
        little = (fmt == FMT_LE16) || (fmt == FMT_LE14);
        narrow = (fmt == FMT_BE14) || (fmt == FMT_LE14);
        for (int w = 0; w < HDR_WORDS; w++) begin
            word = little ? {h[2*w+1], h[2*w]} : {h[2*w], h[2*w+1]};
            if (narrow) begin
                pay[PAYLOAD_BITS-1-14*w -: 14] = word[13:0];
            end else begin
                pay[PAYLOAD_BITS-1-16*w -: 16] = word;
            end
        end
        return pay;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/dhp_front.sv
// Byte collector: gathers header bytes and hands each complete header to the queue.
`default_nettype none

module dhp_front
    import dhp_pkg::*;
#(
    parameter int HEADER_BYTES = HEADER_BYTES_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire in_item_t    s_data,
    input  wire queue_stat_t q_stat,
    output hdr_push_t        q_push
);

    localparam int CW = $clog2(HEADER_BYTES);
    localparam logic [CW-1:0] LAST_POS = CW'(HEADER_BYTES - 1);

    logic [CW-1:0] count_reg, count_next;
    logic          collecting_reg, collecting_next;
    hdr_bytes_t    store_reg, store_next;

    logic          accept;
    logic          take;
    logic [CW-1:0] pos;
    logic          last;

    // Accept a byte whenever the queue can hold a finished header
    assign s_ready = !q_stat.full;
    assign accept  = s_valid && s_ready;

    // A first byte restarts at position 0; drop stray bytes while idle
    assign pos  = s_data.first_byte ? '0 : count_reg;
    assign take = accept && (s_data.first_byte || collecting_reg);
    assign last = (pos == LAST_POS);

    // Merge the incoming byte into the store; bytes past the parsed part are dropped
    always_comb begin
        store_next = store_reg;
        for (int i = 0; i < PARSE_BYTES; i++) begin
            if (take && (32'(pos) == i)) begin
                store_next[i] = s_data.data_byte;
            end
        end
    end

    // Hand the completed header over with its final byte in place
    assign q_push.valid = take && last;
    assign q_push.bytes = store_next;

    // Advance position and collection flag
    always_comb begin
        count_next      = count_reg;
        collecting_next = collecting_reg;
        if (take) begin
            if (last) begin
                count_next      = '0;
                collecting_next = 1'b0;
            end else begin
                count_next      = pos + CW'(1);
                collecting_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            collecting_reg <= 1'b0;
        end else begin
            count_reg      <= count_next;
            collecting_reg <= collecting_next;
        end
    end

    always_ff @(posedge aclk) begin
        store_reg <= store_next;
    end

endmodule

`default_nettype wire

// File: hw/rtl/dhp_queue.sv
// Short queue of collected headers between the collector and the parser.
`default_nettype none

module dhp_queue
    import dhp_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire hdr_push_t q_push,
    input  wire logic      q_pop,
    output queue_stat_t    q_stat,
    output hdr_bytes_t     q_head
);

    localparam int AW   = $clog2(QUEUE_DEPTH);
    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW-1:0]   LAST_SLOT = AW'(QUEUE_DEPTH - 1);
    localparam logic [CNTW-1:0] FULL_CNT  = CNTW'(QUEUE_DEPTH);

    hdr_bytes_t      entry_reg [QUEUE_DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0] fill_reg, fill_next;

    assign q_stat.full  = (fill_reg == FULL_CNT);
    assign q_stat.empty = (fill_reg == '0);
    assign q_head       = entry_reg[rd_ptr_reg];

    // Advance pointers and fill level
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (q_push.valid) begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (q_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (q_push.valid && !q_pop) begin
            fill_next = fill_reg + CNTW'(1);
        end else if (!q_push.valid && q_pop) begin
            fill_next = fill_reg - CNTW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Write the incoming header into its slot
    always_ff @(posedge aclk) begin
        if (q_push.valid) begin
            entry_reg[wr_ptr_reg] <= q_push.bytes;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/dhp_back.sv
// Header parser: sync detection, field unpacking, limit checks and output register.
`default_nettype none

module dhp_back
    import dhp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire queue_stat_t q_stat,
    input  wire hdr_bytes_t  q_head,
    output logic             q_pop,
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_item_t        m_data
);

    // Field positions in the payload, counted from the first payload bit
    localparam int CPF_BIT  = PAYLOAD_BITS - 1 - 38;
    localparam int BLK_MSB  = PAYLOAD_BITS - 1 - 39;
    localparam int FSZ_MSB  = PAYLOAD_BITS - 1 - 46;
    localparam int AMODE_MSB = PAYLOAD_BITS - 1 - 60;
    localparam int SFREQ_MSB = PAYLOAD_BITS - 1 - 66;
    localparam int LFF_MSB  = PAYLOAD_BITS - 1 - 85;

    // Validity limits
    localparam logic [7:0]  MIN_BLOCKS      = 8'd6;
    localparam logic [14:0] MIN_FRAME_BYTES = 15'd96;
    localparam logic [5:0]  MAX_ARRANGEMENT = 6'd12;
    localparam logic [1:0]  LFE_INVALID     = 2'd3;
    localparam logic [7:0]  BLOCKS_512      = 8'd16;
    localparam logic [7:0]  BLOCKS_1024     = 8'd32;
    localparam logic [7:0]  BLOCKS_2048     = 8'd64;

    logic                    m_valid_reg, m_valid_next;
    out_item_t               m_data_reg;
    out_item_t               result;

    logic                    sync_be16, sync_le16, sync_be14, sync_le14;
    logic                    sync_any;
    stream_fmt_t             fmt;
    logic [PAYLOAD_BITS-1:0] pay;
    logic [7:0]              blocks;
    logic [14:0]             fbytes;
    logic [5:0]              amode;
    logic [17:0]             rate;
    logic [1:0]              lff;
    logic                    hdr_ok;

    // Match the four sync forms
    always_comb begin
        sync_be16 = (q_head[0] == SYNC_7F) && (q_head[1] == SYNC_FE) &&
                    (q_head[2] == SYNC_80) && (q_head[3] == SYNC_01);
        sync_le16 = (q_head[0] == SYNC_FE) && (q_head[1] == SYNC_7F) &&
                    (q_head[2] == SYNC_01) && (q_head[3] == SYNC_80);
        sync_be14 = (q_head[0] == SYNC_1F) && (q_head[1] == SYNC_FF) &&
                    (q_head[2] == SYNC_E8) && (q_head[3] == SYNC_00) &&
                    (q_head[4] == SYNC_07) &&
                    ((q_head[5] & SYNC_HI_NIBBLE) == SYNC_HI_NIBBLE);
        sync_le14 = (q_head[0] == SYNC_FF) && (q_head[1] == SYNC_1F) &&
                    (q_head[2] == SYNC_00) && (q_head[3] == SYNC_E8) &&
                    ((q_head[4] & SYNC_HI_NIBBLE) == SYNC_HI_NIBBLE) &&
                    (q_head[5] == SYNC_07);
        sync_any  = sync_be16 || sync_le16 || sync_be14 || sync_le14;
    end

    always_comb begin
        priority if (sync_be16) begin
            fmt = FMT_BE16;
        end else if (sync_le16) begin
            fmt = FMT_LE16;
        end else if (sync_be14) begin
            fmt = FMT_BE14;
        end else begin
            fmt = FMT_LE14;
        end
    end

    // Unpack fields and apply limits
    always_comb begin
        pay    = unpack_payload(q_head, fmt);
        blocks = {1'b0, pay[BLK_MSB -: 7]} + 8'd1;
        fbytes = {1'b0, pay[FSZ_MSB -: 14]} + 15'd1;
        amode  = pay[AMODE_MSB -: 6];
        rate   = rate_lookup(pay[SFREQ_MSB -: 4]);
        lff    = pay[LFF_MSB -: 2];
        hdr_ok = sync_any && (blocks >= MIN_BLOCKS) && (fbytes >= MIN_FRAME_BYTES) &&
                 (amode <= MAX_ARRANGEMENT) && (rate != 18'd0) && (lff != LFE_INVALID);

        result = '0;
        if (sync_any) begin
            result.sync_ok             = 1'b1;
            result.header_valid        = hdr_ok;
            result.stream_format       = fmt;
            result.crc_present         = pay[CPF_BIT];
            result.sample_blocks       = blocks;
            result.frame_bytes         = fbytes;
            result.channel_arrangement = amode;
            result.sample_rate_hz      = rate;
            result.lfe_mode            = lff;
            if (hdr_ok) begin
                result.sample_count = {blocks, 5'b0};
                priority if (blocks == BLOCKS_512) begin
                    result.spdif_burst_type = BURST_512;
                end else if (blocks == BLOCKS_1024) begin
                    result.spdif_burst_type = BURST_1024;
                end else if (blocks == BLOCKS_2048) begin
                    result.spdif_burst_type = BURST_2048;
                end else begin
                    result.spdif_burst_type = BURST_NONE;
                end
            end
        end
    end

    // Load the output register when it is empty or being drained
    assign q_pop = !q_stat.empty && (!m_valid_reg || m_ready);

    always_comb begin
        m_valid_next = m_valid_reg;
        if (q_pop) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

// File: hw/rtl/dts_header_parser_unit.sv
// Top level of the DTS core frame header parser.
//
// Input channel (s_valid/s_ready/s_data) carries one header byte per transfer;
// first_byte marks the start of a candidate header and restarts collection.
// Bytes with first_byte low while no header is being collected are dropped.
// After HEADER_BYTES bytes one result leaves on the m_valid/m_ready/m_data
// channel: sync form, unpacked fields, sample rate in Hz, sample count and
// S/PDIF burst type. Only the first fourteen bytes are parsed.
// One byte is taken per clock while s_ready is high.
// After the last byte's transfer the header is written into the queue, and
// m_valid rises once the parser has loaded it into the output register.
// The collector feeds a two-entry header queue and the parser drains it into
// an output register; while the receiver stalls, bytes keep being taken until
// the queue is full, then s_ready drops until the parser frees a slot.
// Reset (aresetn low, synchronous) empties the queue and output register and
// leaves the collector idle, waiting for a first byte.
`default_nettype none

module dts_header_parser_unit
    import dhp_pkg::*;
#(
    parameter int HEADER_BYTES = HEADER_BYTES_DEFAULT
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_item_t s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output out_item_t     m_data
);

    hdr_push_t   q_push;
    queue_stat_t q_stat;
    hdr_bytes_t  q_head;
    logic        q_pop;

    dhp_front #(
        .HEADER_BYTES(HEADER_BYTES)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_stat  (q_stat),
        .q_push  (q_push)
    );

    dhp_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_push  (q_push),
        .q_pop   (q_pop),
        .q_stat  (q_stat),
        .q_head  (q_head)
    );

    dhp_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_stat  (q_stat),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Never push into a full queue nor pop an empty one
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_push.valid && q_stat.full) && !(q_pop && q_stat.empty))
        else $error("header queue overflow or underflow");

    // A valid header always comes with a matched sync
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.header_valid) |-> m_data.sync_ok)
        else $error("header_valid without sync");

    // Burst type and sample count are only reported for valid headers
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.header_valid) |->
            (m_data.spdif_burst_type == BURST_NONE) && (m_data.sample_count == '0))
        else $error("burst type or sample count on invalid header");

    // A popped header shows up on the output in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> m_valid)
        else $error("popped header not presented");

endmodule

`default_nettype wire
